// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the receiver (efrlm_checker.sv).
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define EFRLM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define EFRLM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/efrlm_pkg.sv =====
// Shared types and constants for the escaped frame receiver and link monitor.
// No dependencies; imported by the core, the top level and the checker.
`default_nettype none

package efrlm_pkg;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Reset values of the configuration registers
	localparam logic        RST_LINK_ENABLE  = 1'b0;
	localparam logic        RST_LINK_ROLE    = 1'b0;
	localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd100;
	localparam logic [7:0]  RST_BEGIN_CODE   = 8'd2;
	localparam logic [7:0]  RST_END_CODE     = 8'd3;
	localparam logic [7:0]  RST_ESCAPE_CODE  = 8'd16;

	typedef enum logic [2:0] {
		REG_LINK_ENABLE  = 3'd0,
		REG_LINK_ROLE    = 3'd1,
		REG_IDLE_TIMEOUT = 3'd2,
		REG_BEGIN_CODE   = 3'd3,
		REG_END_CODE     = 3'd4,
		REG_ESCAPE_CODE  = 3'd5
	} reg_idx_t;

	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef enum logic {
		ROLE_MASTER = 1'b0,
		ROLE_SLAVE  = 1'b1
	} link_role_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
		logic       sink_full;
	} req_t;

	typedef struct packed {
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        overrun_flag;
		logic        frame_done;
		logic [15:0] frame_length;
		logic        framing_error;
		logic        connect_event;
		logic        disconnect_event;
		logic        link_up;
		logic        flush_queues;
		logic        send_frame;
	} rsp_t;

	typedef struct packed {
		logic        link_enable;
		logic        link_role;
		logic [15:0] idle_timeout_ticks;
		logic [7:0]  begin_code;
		logic [7:0]  end_code;
		logic [7:0]  escape_code;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/efrlm_core.sv =====
// Deframing and link state: holds frame/escape/count/idle/link state and
// works out one result per beat. Depends on efrlm_pkg.
`default_nettype none

module efrlm_core
	import efrlm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic clear,
	input  wire logic accept,
	input  wire req_t req,
	output rsp_t      rsp
);

	logic        in_frame_q;
	logic        escape_pending_q;
	logic [15:0] payload_count_q;
	logic [15:0] idle_ticks_q;
	logic        link_connected_q;

	logic        in_frame_d;
	logic        escape_pending_d;
	logic [15:0] payload_count_d;
	logic [15:0] idle_ticks_d;
	logic        link_connected_d;

	logic [15:0] idle_inc;

	assign idle_inc = (idle_ticks_q == COUNT_MAX) ? idle_ticks_q : idle_ticks_q + 16'd1;

	always_comb begin
		in_frame_d       = in_frame_q;
		escape_pending_d = escape_pending_q;
		payload_count_d  = payload_count_q;
		idle_ticks_d     = idle_ticks_q;
		link_connected_d = link_connected_q;
		rsp              = '0;

		if (cfg.link_enable) begin
			if (req_kind_t'(req.req_type) == REQ_BYTE) begin
				idle_ticks_d = '0;
				if (!in_frame_q) begin
					// outside a frame only the begin code matters
					if (req.rx_byte == cfg.begin_code) begin
						in_frame_d       = 1'b1;
						escape_pending_d = 1'b0;
						payload_count_d  = '0;
					end
				end else if (!escape_pending_q && req.rx_byte == cfg.end_code) begin
					rsp.frame_done   = 1'b1;
					rsp.frame_length = payload_count_q;
					rsp.send_frame   = 1'b1;
					in_frame_d       = 1'b0;
					payload_count_d  = '0;
					if (!link_connected_q) begin
						link_connected_d  = 1'b1;
						rsp.connect_event = 1'b1;
						rsp.flush_queues  = 1'b1;
					end
				end else if (!escape_pending_q && req.rx_byte == cfg.escape_code) begin
					escape_pending_d = 1'b1;
				end else begin
					escape_pending_d = 1'b0;
					if (link_connected_q) begin
						rsp.data_valid   = 1'b1;
						rsp.data_byte    = req.rx_byte;
						rsp.overrun_flag = req.sink_full;
						if (payload_count_q != COUNT_MAX)
							payload_count_d = payload_count_q + 16'd1;
					end
				end
			end else begin
				idle_ticks_d = idle_inc;
				// a zero timeout behaves as one since idle_inc is at least one
				if (idle_inc >= cfg.idle_timeout_ticks) begin
					rsp.framing_error = in_frame_q;
					if (link_connected_q) begin
						link_connected_d     = 1'b0;
						rsp.disconnect_event = 1'b1;
						rsp.flush_queues     = 1'b1;
					end
					rsp.send_frame   = (link_role_t'(cfg.link_role) == ROLE_MASTER);
					in_frame_d       = 1'b0;
					escape_pending_d = 1'b0;
					payload_count_d  = '0;
					idle_ticks_d     = '0;
				end
			end
			rsp.link_up = link_connected_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q       <= 1'b0;
			escape_pending_q <= 1'b0;
			payload_count_q  <= '0;
			idle_ticks_q     <= '0;
			link_connected_q <= 1'b0;
		end else if (clear) begin
			in_frame_q       <= 1'b0;
			escape_pending_q <= 1'b0;
			payload_count_q  <= '0;
			idle_ticks_q     <= '0;
			link_connected_q <= 1'b0;
		end else if (accept) begin
			in_frame_q       <= in_frame_d;
			escape_pending_q <= escape_pending_d;
			payload_count_q  <= payload_count_d;
			idle_ticks_q     <= idle_ticks_d;
			link_connected_q <= link_connected_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/escaped_frame_receiver_link_monitor.sv =====
// Latency: a beat accepted at one edge shows its result at rsp from the next cycle.
// Throughput: one beat per cycle; the single result register is the only stage,
// and req_stall rises only while that register holds a result that is stalled.
// Reset: arst_n clears all link state and loads the register defaults at once.
// Writing 0 to link_enable clears link state as well.
`default_nettype none

module escaped_frame_receiver_link_monitor
	import efrlm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output rsp_t                       rsp
);

	cfg_t     cfg_q;
	logic     cfg_wr;
	logic     clear;
	reg_idx_t reg_idx;
	logic     accept;
	rsp_t     rsp_d;
	logic     rsp_valid_q;
	rsp_t     rsp_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign clear   = cfg_wr && (reg_idx == REG_LINK_ENABLE) && !pwdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_enable        <= RST_LINK_ENABLE;
			cfg_q.link_role          <= RST_LINK_ROLE;
			cfg_q.idle_timeout_ticks <= RST_IDLE_TIMEOUT;
			cfg_q.begin_code         <= RST_BEGIN_CODE;
			cfg_q.end_code           <= RST_END_CODE;
			cfg_q.escape_code        <= RST_ESCAPE_CODE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LINK_ENABLE:  cfg_q.link_enable        <= pwdata[0];
				REG_LINK_ROLE:    cfg_q.link_role          <= pwdata[0];
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout_ticks <= pwdata[15:0];
				REG_BEGIN_CODE:   cfg_q.begin_code         <= pwdata[7:0];
				REG_END_CODE:     cfg_q.end_code           <= pwdata[7:0];
				REG_ESCAPE_CODE:  cfg_q.escape_code        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_LINK_ENABLE:  prdata[0]    = cfg_q.link_enable;
			REG_LINK_ROLE:    prdata[0]    = cfg_q.link_role;
			REG_IDLE_TIMEOUT: prdata[15:0] = cfg_q.idle_timeout_ticks;
			REG_BEGIN_CODE:   prdata[7:0]  = cfg_q.begin_code;
			REG_END_CODE:     prdata[7:0]  = cfg_q.end_code;
			REG_ESCAPE_CODE:  prdata[7:0]  = cfg_q.escape_code;
			default:          prdata       = '0;
		endcase
	end

	// A new beat goes in whenever the result register is free or being drained.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	efrlm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.clear  (clear),
		.accept (accept),
		.req    (req),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (!req_stall)
			rsp_valid_q <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (accept)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== src/efrlm_checker.sv =====
// Port-level checks for the escaped frame receiver, bound to the top level.
// Depends on efrlm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module efrlm_checker
	import efrlm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pready,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	`EFRLM_ASSERT(a_rsp_hold,
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp),
		"stalled result beat changed")

	`EFRLM_ASSERT(a_flush_on_event,
		rsp_valid |-> rsp.flush_queues == (rsp.connect_event || rsp.disconnect_event),
		"flush does not match a link event")

	`EFRLM_ASSERT(a_done_link_up,
		rsp_valid && (rsp.frame_done || rsp.data_valid) |-> rsp.link_up || !rsp.data_valid,
		"payload delivered with link down")

	`EFRLM_ASSERT(a_disc_down,
		rsp_valid && rsp.disconnect_event |-> !rsp.link_up && !rsp.connect_event
			&& !rsp.data_valid,
		"disconnect beat inconsistent")

	`EFRLM_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind escaped_frame_receiver_link_monitor efrlm_checker u_efrlm_checker (.*);

`default_nettype wire

// ===== tb/efrlm_deframe_checker.sv =====
// Checker for the escaped frame receiver: watches APB writes and both beat channels,
// predicts each result from its own copy of the link state and compares field by field.
// Depends on efrlm_pkg only.

module efrlm_deframe_checker
	import efrlm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	input  wire logic                  pready,
	input  wire logic                  req_valid,
	input  wire logic                  req_stall,
	input  wire req_t                  req,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_stall,
	input  wire rsp_t                  rsp,
	output int                         outstanding,
	output int                         fail_count
);

	cfg_t        cfg;
	logic        in_frame;
	logic        esc_pending;
	logic [15:0] payload_cnt;
	logic [15:0] idle_cnt;
	logic        connected;
	rsp_t        expected_q[$];
	int          result_no;

	function automatic void clear_link_state();
		in_frame    = 1'b0;
		esc_pending = 1'b0;
		payload_cnt = '0;
		idle_cnt    = '0;
		connected   = 1'b0;
	endfunction

	// Advances the link state by one beat and returns the result it should give.
	function automatic rsp_t deframe_step(req_t beat);
		rsp_t r;
		r = '0;
		if (cfg.link_enable) begin
			if (beat.req_type == REQ_BYTE) begin
				idle_cnt = '0;
				if (!in_frame) begin
					if (beat.rx_byte == cfg.begin_code) begin
						in_frame    = 1'b1;
						esc_pending = 1'b0;
						payload_cnt = '0;
					end
				end else if (!esc_pending && beat.rx_byte == cfg.end_code) begin
					r.frame_done   = 1'b1;
					r.frame_length = payload_cnt;
					r.send_frame   = 1'b1;
					in_frame       = 1'b0;
					payload_cnt    = '0;
					if (!connected) begin
						connected       = 1'b1;
						r.connect_event = 1'b1;
						r.flush_queues  = 1'b1;
					end
				end else if (!esc_pending && beat.rx_byte == cfg.escape_code) begin
					esc_pending = 1'b1;
				end else begin
					esc_pending = 1'b0;
					// payload is swallowed without a count while the link is down
					if (connected) begin
						r.data_valid   = 1'b1;
						r.data_byte    = beat.rx_byte;
						r.overrun_flag = beat.sink_full;
						if (payload_cnt != COUNT_MAX)
							payload_cnt = payload_cnt + 16'd1;
					end
				end
			end else begin
				if (idle_cnt != COUNT_MAX)
					idle_cnt = idle_cnt + 16'd1;
				// a zero timeout behaves as one, since the count is at least 1 here
				if (idle_cnt >= cfg.idle_timeout_ticks) begin
					r.framing_error = in_frame;
					if (connected) begin
						connected          = 1'b0;
						r.disconnect_event = 1'b1;
						r.flush_queues     = 1'b1;
					end
					r.send_frame = (cfg.link_role == ROLE_MASTER);
					in_frame     = 1'b0;
					esc_pending  = 1'b0;
					payload_cnt  = '0;
					idle_cnt     = '0;
				end
			end
			r.link_up = connected;
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		$display("mismatch: %s", msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				result_no, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			cfg = '{RST_LINK_ENABLE, RST_LINK_ROLE, RST_IDLE_TIMEOUT,
				RST_BEGIN_CODE, RST_END_CODE, RST_ESCAPE_CODE};
			clear_link_state();
			expected_q.delete();
			result_no  = 0;
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_LINK_ENABLE: begin
						cfg.link_enable = pwdata[0];
						if (!pwdata[0])
							clear_link_state();
					end
					REG_LINK_ROLE:    cfg.link_role          = pwdata[0];
					REG_IDLE_TIMEOUT: cfg.idle_timeout_ticks = pwdata[15:0];
					REG_BEGIN_CODE:   cfg.begin_code         = pwdata[7:0];
					REG_END_CODE:     cfg.end_code           = pwdata[7:0];
					REG_ESCAPE_CODE:  cfg.escape_code        = pwdata[7:0];
					default: ;
				endcase
			end
			// a result never belongs to a beat taken at the same edge, so pop first
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no beat waiting",
						result_no));
				end else begin
					want = expected_q.pop_front();
					check_field("data_valid", 16'(rsp.data_valid), 16'(want.data_valid));
					check_field("data_byte", 16'(rsp.data_byte), 16'(want.data_byte));
					check_field("overrun_flag", 16'(rsp.overrun_flag),
						16'(want.overrun_flag));
					check_field("frame_done", 16'(rsp.frame_done), 16'(want.frame_done));
					check_field("frame_length", rsp.frame_length, want.frame_length);
					check_field("framing_error", 16'(rsp.framing_error),
						16'(want.framing_error));
					check_field("connect_event", 16'(rsp.connect_event),
						16'(want.connect_event));
					check_field("disconnect_event", 16'(rsp.disconnect_event),
						16'(want.disconnect_event));
					check_field("link_up", 16'(rsp.link_up), 16'(want.link_up));
					check_field("flush_queues", 16'(rsp.flush_queues),
						16'(want.flush_queues));
					check_field("send_frame", 16'(rsp.send_frame), 16'(want.send_frame));
				end
				result_no++;
			end
			if (req_valid && !req_stall)
				expected_q.push_back(deframe_step(req));
		end
		outstanding = expected_q.size();
	end

endmodule

// ===== tb/tb_escaped_frame_receiver_link_monitor.sv =====
// Testbench top for the escaped frame receiver and link monitor: clock, reset, APB
// set-up, beat stimulus with random idling, and the verdict.
// Depends on efrlm_pkg, the block and efrlm_deframe_checker.

module tb_escaped_frame_receiver_link_monitor;
	import efrlm_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_BEATS   = 200;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;

	int   outstanding;
	int   fail_count;
	int   cycle_count;
	int   sent;
	int   hold_cycles_req;
	logic quiet;
	cfg_t shadow;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	escaped_frame_receiver_link_monitor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	efrlm_deframe_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// All tasks are entered and left at a falling edge.
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_LINK_ENABLE:  shadow.link_enable        = val[0];
			REG_LINK_ROLE:    shadow.link_role          = val[0];
			REG_IDLE_TIMEOUT: shadow.idle_timeout_ticks = val[15:0];
			REG_BEGIN_CODE:   shadow.begin_code         = val[7:0];
			REG_END_CODE:     shadow.end_code           = val[7:0];
			REG_ESCAPE_CODE:  shadow.escape_code        = val[7:0];
			default: ;
		endcase
	endtask

	task automatic send_beat(req_t beat);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		sent++;
	endtask

	function automatic req_t byte_beat(logic [7:0] b);
		req_t r;
		r.req_type  = REQ_BYTE;
		r.rx_byte   = b;
		r.sink_full = ($urandom_range(0, 3) == 0);
		return r;
	endfunction

	// rx_byte and sink_full are random on ticks too: the block must ignore them
	function automatic req_t tick_beat();
		req_t r;
		r.req_type  = REQ_TICK;
		r.rx_byte   = 8'($urandom_range(0, 255));
		r.sink_full = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic drain_results();
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic send_frame_seq(int n_payload, bit close);
		logic [7:0] b;
		send_beat(byte_beat(shadow.begin_code));
		repeat (n_payload) begin
			b = 8'($urandom_range(0, 255));
			if (b == shadow.end_code || b == shadow.escape_code || $urandom_range(0, 9) == 0)
				send_beat(byte_beat(shadow.escape_code));
			send_beat(byte_beat(b));
		end
		if (close)
			send_beat(byte_beat(shadow.end_code));
	endtask

	// run of ticks that now and then reaches the timeout
	task automatic tick_run();
		int n;
		if (shadow.idle_timeout_ticks <= 16'd11)
			n = $urandom_range(1, int'(shadow.idle_timeout_ticks) + 1);
		else
			n = $urandom_range(1, 12);
		repeat (n) send_beat(tick_beat());
	endtask

	task automatic random_unit();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12) begin
			send_frame_seq($urandom_range(0, 8), 1'b1);
		end else if (pick < 15) begin
			tick_run();
		end else if (pick < 17) begin
			send_beat(byte_beat(8'($urandom_range(0, 255))));
		end else if (pick < 19) begin
			// frame left open, then idle
			send_frame_seq($urandom_range(0, 4), 1'b0);
			tick_run();
		end else begin
			send_beat(tick_beat());
		end
	endtask

	task automatic pick_settings(int p);
		cfg_t s;
		s.link_role = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
		if (p == 0)
			s.idle_timeout_ticks = 16'd1;
		else if (p == 1)
			s.idle_timeout_ticks = 16'hFFFF;
		else if ($urandom_range(0, 3) == 0)
			s.idle_timeout_ticks = 16'd0;
		else
			s.idle_timeout_ticks = 16'($urandom_range(2, 10));
		case (p % 5)
			0: begin
				s.begin_code  = RST_BEGIN_CODE;
				s.end_code    = RST_END_CODE;
				s.escape_code = RST_ESCAPE_CODE;
			end
			1: begin
				s.begin_code  = 8'($urandom_range(0, 255));
				s.end_code    = 8'($urandom_range(0, 255));
				s.escape_code = 8'($urandom_range(0, 255));
			end
			2: begin
				// end and escape collide: the end test wins
				s.begin_code  = 8'($urandom_range(0, 255));
				s.end_code    = 8'($urandom_range(0, 255));
				s.escape_code = s.end_code;
			end
			3: begin
				s.begin_code  = 8'($urandom_range(0, 255));
				s.end_code    = s.begin_code;
				s.escape_code = 8'($urandom_range(0, 255));
			end
			default: begin
				s.begin_code  = 8'h00;
				s.end_code    = 8'hFF;
				s.escape_code = 8'($urandom_range(0, 255));
			end
		endcase
		if ($urandom_range(0, 1))
			write_reg(REG_LINK_ENABLE, 32'd0);
		write_reg(REG_LINK_ROLE, 32'(s.link_role));
		write_reg(REG_IDLE_TIMEOUT, 32'(s.idle_timeout_ticks));
		write_reg(REG_BEGIN_CODE, 32'(s.begin_code));
		write_reg(REG_END_CODE, 32'(s.end_code));
		write_reg(REG_ESCAPE_CODE, 32'(s.escape_code));
		write_reg(REG_LINK_ENABLE, 32'd1);
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver side: a random hold-off per result, and a long hold when asked for.
	initial begin : rsp_side
		int gap;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_cycles_req != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_cycles_req) @(negedge clk);
				hold_cycles_req = 0;
			end
			gap = quiet ? 0 : $urandom_range(0, 11);
			if (gap != 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int         p;
		bit         paused;
		req_t       r;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		req_valid       = 1'b0;
		req             = '0;
		quiet           = 1'b0;
		hold_cycles_req = 0;
		sent            = 0;
		shadow = '{RST_LINK_ENABLE, RST_LINK_ROLE, RST_IDLE_TIMEOUT,
			RST_BEGIN_CODE, RST_END_CODE, RST_ESCAPE_CODE};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// still disabled out of reset: all-zero results
		send_beat(byte_beat(shadow.begin_code));
		send_beat(byte_beat(8'h41));
		send_beat(tick_beat());
		drain_results();

		write_reg(REG_IDLE_TIMEOUT, 32'd3);
		write_reg(REG_LINK_ROLE, 32'(ROLE_MASTER));
		write_reg(REG_LINK_ENABLE, 32'd1);
		repeat (3) send_beat(tick_beat());
		send_beat(byte_beat(8'h55));
		send_beat(byte_beat(shadow.escape_code));
		// first frame: payload swallowed while down, close brings the link up
		send_beat(byte_beat(shadow.begin_code));
		send_beat(byte_beat(8'h41));
		send_beat(byte_beat(shadow.end_code));
		send_beat(byte_beat(shadow.begin_code));
		send_beat(byte_beat(8'h00));
		send_beat(byte_beat(shadow.escape_code));
		send_beat(byte_beat(shadow.end_code));
		send_beat(byte_beat(shadow.begin_code));
		r = byte_beat(8'hFF);
		r.sink_full = 1'b1;
		send_beat(r);
		send_beat(byte_beat(shadow.end_code));
		// open frame with an escaped escape, then timeout while up
		send_beat(byte_beat(shadow.begin_code));
		send_beat(byte_beat(shadow.escape_code));
		send_beat(byte_beat(shadow.escape_code));
		repeat (3) send_beat(tick_beat());
		drain_results();

		write_reg(REG_LINK_ROLE, 32'(ROLE_SLAVE));
		write_reg(REG_IDLE_TIMEOUT, 32'd0);
		send_beat(tick_beat());
		send_beat(byte_beat(shadow.begin_code));
		send_beat(byte_beat(shadow.end_code));
		drain_results();
		// disabling drops the link with no event
		write_reg(REG_LINK_ENABLE, 32'd0);
		write_reg(REG_LINK_ENABLE, 32'd1);
		send_beat(tick_beat());
		drain_results();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			pick_settings(p);
			sent   = 0;
			paused = 1'b0;
			// long receiver hold while beats keep coming, so the input stalls
			if (p == 2)
				hold_cycles_req = 80;
			while (sent < PHASE_BEATS) begin
				quiet = (p == 4) && (sent < PHASE_BEATS / 2);
				if (p == 3 && !paused && sent >= PHASE_BEATS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				random_unit();
			end
			quiet = 1'b0;
			drain_results();
			if (p == 3) begin
				write_reg(REG_LINK_ENABLE, 32'd0);
				repeat (15)
					send_beat($urandom_range(0, 1) ? tick_beat()
						: byte_beat(8'($urandom_range(0, 255))));
				drain_results();
			end
		end

		drain_results();
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
